// ===== rtl/last_subsequence_match_defines.svh =====
// Assertion macros used by the top-level RTL file. Each expects clk and arst_n in scope.
`ifndef LAST_SUBSEQUENCE_MATCH_DEFINES_SVH
`define LAST_SUBSEQUENCE_MATCH_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define LSM_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("last_subsequence_match: check failed");

// Consequent must hold in the cycle after the antecedent.
`define LSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("last_subsequence_match: check failed");

`else

`define LSM_ASSERT_SAME(lbl, ante, cons)
`define LSM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/lsm_pkg.sv =====
`timescale 1ns / 1ps

package lsm_pkg;

	localparam int VALUE_W  = 32;
	localparam int POS_W    = 16;
	localparam int STATUS_W = 2;

	localparam logic CMD_PATTERN = 1'b0;
	localparam logic CMD_TEXT    = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 2'd0,
		ST_SHORT_TEXT    = 2'd1,
		ST_PAT_OVERFLOW  = 2'd2,
		ST_TEXT_OVERFLOW = 2'd3
	} lsm_status_t;

	// Controls broadcast to every cell of the chain.
	typedef struct packed {
		logic clear;  // drop all prefix-match bits
		logic load;   // write the selected cell's pattern word
		logic step;   // advance the chain by one text word
	} lsm_cell_ctl_t;

endpackage

// ===== rtl/lsm_cell.sv =====
`timescale 1ns / 1ps

module lsm_cell #(
	parameter int W = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lsm_pkg::lsm_cell_ctl_t ctl,
	input  logic                   wr_sel,
	input  logic [W-1:0]           word,
	input  logic                   prev_match,
	output logic                   match_d,
	output logic                   match_q
);
	import lsm_pkg::*;

	logic [W-1:0] pat_q;

	// Pattern prefix up to this cell ends at the current text word.
	assign match_d = prev_match && (pat_q == word);

	always_ff @(posedge clk) begin
		if (ctl.load && wr_sel) begin
			pat_q <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.clear) begin
			match_q <= 1'b0;
		end else if (ctl.step) begin
			match_q <= match_d;
		end
	end

endmodule

// ===== rtl/last_subsequence_match.sv =====
`timescale 1ns / 1ps
`include "last_subsequence_match_defines.svh"

// Exact contiguous sequence search that reports the last occurrence. Load the
// pattern as cmd 0 items (last marks its final word), then stream the text as
// cmd 1 items; on the text item marked last one result comes out: the 1-based
// start of the last full match (0 if none) and a status (ok, pattern longer
// than text, pattern overflow, text overflow). Every item, pattern or text,
// takes one clock: the pattern sits in a row of PATTERN_MAX cells, each with
// its own word comparator and prefix-match bit, and the whole row advances
// once per text word. The result is registered and shows in the cycle after the
// final text word is accepted when the output is free; while a stalled output
// holds a result, a spare register takes the next one, and the input stalls
// only once both are full. No clearing pass is needed after reset.
module last_subsequence_match #(
	parameter int             PATTERN_MAX = 16,
	parameter longint unsigned TEXT_MAX   = 65535,
	parameter int             WORD_WIDTH  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                cmd,
	input  logic signed [lsm_pkg::VALUE_W-1:0]  value,
	input  logic                                last,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic        [lsm_pkg::POS_W-1:0]    position,
	output logic        [lsm_pkg::STATUS_W-1:0] status
);
	import lsm_pkg::*;

	localparam int CmpW = (WORD_WIDTH < VALUE_W) ? WORD_WIDTH : VALUE_W;
	localparam int LenW = $clog2(PATTERN_MAX + 1);
	localparam int IdxW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int CntW = $clog2(TEXT_MAX + 1);
	localparam int SumW = ((CntW > LenW) ? CntW : LenW) + 1;

	logic [LenW-1:0] len_q;
	logic            too_big_q;
	logic            new_pat_q;
	logic [CntW-1:0] count_q;
	logic            text_long_q;
	logic [CntW-1:0] start_q;

	logic            result_valid_q;
	logic [POS_W-1:0] position_q;
	lsm_status_t     status_q;
	logic            spare_valid_q;
	logic [POS_W-1:0] spare_position_q;
	lsm_status_t     spare_status_q;

	logic                 item_fire;
	logic                 pat_fire;
	logic                 text_fire;
	logic [CmpW-1:0]      word;
	logic [LenW-1:0]      eff_len;
	logic                 eff_big;
	logic                 room;
	logic                 ovf;
	logic [CntW-1:0]      cnt_inc;
	logic [CntW-1:0]      cnt_new;
	logic [CntW-1:0]      start_new;
	logic [IdxW-1:0]      tail_idx;
	logic                 found;
	logic                 short_text;
	logic                 text_end;
	logic [CntW+POS_W-1:0] pos_wide;
	logic [POS_W-1:0]     res_pos;
	logic                 out_free;
	lsm_status_t          status_d;
	lsm_cell_ctl_t        cell_ctl;

	logic [PATTERN_MAX:0]   chain_q;
	logic [PATTERN_MAX-1:0] chain_d;
	logic [PATTERN_MAX-1:0] wr_sel;

	assign item_stall = spare_valid_q;
	assign item_fire  = item_valid && !item_stall;
	assign pat_fire   = item_fire && (cmd == CMD_PATTERN);
	assign text_fire  = item_fire && (cmd == CMD_TEXT);
	assign text_end   = text_fire && last;
	assign word       = value[CmpW-1:0];

	// A new pattern restarts at length zero.
	assign eff_len = new_pat_q ? '0 : len_q;
	assign eff_big = new_pat_q ? 1'b0 : too_big_q;
	assign room    = (eff_len < LenW'(PATTERN_MAX));

	assign ovf     = (count_q >= CntW'(TEXT_MAX));
	assign cnt_inc = count_q + 1'b1;
	assign cnt_new = ovf ? count_q : cnt_inc;

	assign cell_ctl.load  = pat_fire && room;
	assign cell_ctl.step  = text_fire && !ovf && (len_q != '0);
	assign cell_ctl.clear = pat_fire || text_end;

	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			wr_sel[i] = (eff_len == LenW'(i));
		end
	end

	assign chain_q[0] = 1'b1;

	for (genvar gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
		lsm_cell #(
			.W(CmpW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl),
			.wr_sel     (wr_sel[gi]),
			.word       (word),
			.prev_match (chain_q[gi]),
			.match_d    (chain_d[gi]),
			.match_q    (chain_q[gi+1])
		);
	end

	// Whole pattern ends at this word: its start is count_q + 2 - length.
	assign tail_idx  = IdxW'(len_q - 1'b1);
	assign found     = cell_ctl.step && chain_d[tail_idx];
	assign start_new = CntW'(cnt_inc - CntW'(len_q) + 1'b1);

	assign short_text = (SumW'(len_q) > SumW'(cnt_new));

	always_comb begin
		if (too_big_q) begin
			status_d = ST_PAT_OVERFLOW;
		end else if (text_long_q || ovf) begin
			status_d = ST_TEXT_OVERFLOW;
		end else if (short_text) begin
			status_d = ST_SHORT_TEXT;
		end else begin
			status_d = ST_OK;
		end
	end

	assign pos_wide = {{POS_W{1'b0}}, (found ? start_new : start_q)};
	assign res_pos  = (status_d == ST_OK) ? pos_wide[POS_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			too_big_q   <= 1'b0;
			new_pat_q   <= 1'b1;
			count_q     <= '0;
			text_long_q <= 1'b0;
			start_q     <= '0;
		end else if (pat_fire) begin
			len_q       <= room ? LenW'(eff_len + 1'b1) : eff_len;
			too_big_q   <= eff_big || !room;
			new_pat_q   <= last;
			count_q     <= '0;
			text_long_q <= 1'b0;
			start_q     <= '0;
		end else if (text_fire) begin
			new_pat_q <= 1'b1;
			if (last) begin
				count_q     <= '0;
				text_long_q <= 1'b0;
				start_q     <= '0;
			end else begin
				count_q     <= cnt_new;
				text_long_q <= text_long_q || ovf;
				if (found) begin
					start_q <= start_new;
				end
			end
		end
	end

	// The output register drains first; the spare catches a result that
	// arrives while the output is held, and moves up as the output drains.
	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			spare_valid_q  <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= spare_valid_q || text_end;
			spare_valid_q  <= 1'b0;
		end else begin
			spare_valid_q <= spare_valid_q || text_end;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (spare_valid_q) begin
				status_q   <= spare_status_q;
				position_q <= spare_position_q;
			end else if (text_end) begin
				status_q   <= status_d;
				position_q <= res_pos;
			end
		end else if (text_end) begin
			spare_status_q   <= status_d;
			spare_position_q <= res_pos;
		end
	end

	assign result_valid = result_valid_q;
	assign position     = position_q;
	assign status       = status_q;

	`LSM_ASSERT_SAME(a_err_no_pos, result_valid && (status != ST_OK), position == '0)
	`LSM_ASSERT_SAME(a_len_bound, 1'b1, len_q <= LenW'(PATTERN_MAX))
	`LSM_ASSERT_SAME(a_long_full, text_long_q, count_q == CntW'(TEXT_MAX))
	`LSM_ASSERT_NEXT(a_end_clears, text_end, (count_q == '0) && (start_q == '0) && !text_long_q)
	`LSM_ASSERT_NEXT(a_pat_restart, pat_fire, new_pat_q == $past(last))

endmodule
